// File: hdl/dcs_pkg.sv
`timescale 1ns / 1ps

package dcs_pkg;

   localparam int CODE_COUNT_DEF = 1024;

   localparam int COEF_W    = 48;
   localparam int CAP_W     = 24;
   localparam int TARGET_W  = 24;
   localparam int SEL_W     = 2;
   localparam int BEST_W    = 10;
   localparam int CSR_IDX_W = 3;

   localparam int VAL_W    = 64;
   localparam int LIMB_W   = 32;
   localparam int ACC_W    = 128;
   localparam int DIST_W   = 29;

   localparam int CAP_FRAC    = 20;
   localparam int CHARGE_FRAC = 72;

   // 2^32 / 0.160218 in units of 1e-6, rounded to nearest
   localparam logic [VAL_W-1:0] CHARGE_SCALE =
      ((64'd1000000 << 32) + 64'd80109) / 64'd160218;

   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] REG_COEF_CUBIC  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_SQUARE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_LINEAR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CAP_HIGH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CAP_MEDIUM  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CAP_LOW     = 3'd6;

   localparam logic [SEL_W-1:0] SEL_LOW    = 2'd0;
   localparam logic [SEL_W-1:0] SEL_MEDIUM = 2'd1;

   typedef enum logic [1:0] {
      SHIFT_NONE,
      SHIFT_CAP,
      SHIFT_CHARGE
   } shift_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_ISSUE,
      MUL_DRAIN,
      MUL_ROUND
   } mul_state_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_ISSUE,
      SEQ_WAIT,
      SEQ_DIST,
      SEQ_DONE
   } seq_state_type;

   // which multiplication of the per-code chain is in flight
   typedef enum logic [2:0] {
      STEP_SQUARE,
      STEP_LINEAR,
      STEP_OFFSET,
      STEP_CAP,
      STEP_CHARGE
   } step_type;

   typedef struct packed {
      logic              start;
      logic [VAL_W-1:0]  x;      // signed operand
      logic [VAL_W-1:0]  y;      // unsigned operand, two limbs
      shift_type         shift;
   } mul_cmd_type;

   typedef struct packed {
      logic              done;
      logic [VAL_W-1:0]  result; // signed, rounded and saturated
   } mul_rsp_type;

   typedef struct packed {
      logic                start;
      logic [CAP_W-1:0]    cap;
      logic [TARGET_W-1:0] target;
   } seq_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [BEST_W-1:0] best_code;
   } seq_sts_type;

endpackage

// File: hdl/dcs_mul_unit.sv
`timescale 1ns / 1ps

// Shared 32x32 multiply-accumulate: sign-magnitude product of a 64-bit signed
// operand and a two-limb unsigned operand, rounded half away from zero,
// shifted and saturated to 64 bits.
module dcs_mul_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  dcs_pkg::mul_cmd_type cmd,
   output dcs_pkg::mul_rsp_type rsp
);

   dcs_pkg::mul_state_type state_ff, state_in;

   logic                            neg_ff, neg_in;
   logic [dcs_pkg::VAL_W-1:0]       mag_ff, mag_in;
   logic [dcs_pkg::VAL_W-1:0]       y_ff, y_in;
   logic                            wide_ff, wide_in;
   dcs_pkg::shift_type              shift_ff, shift_in;
   logic [1:0]                      term_ff, term_in;
   logic [2*dcs_pkg::LIMB_W-1:0]    pp_ff, pp_in;
   logic [1:0]                      pp_pos_ff, pp_pos_in;
   logic                            pp_vld_ff, pp_vld_in;
   logic [dcs_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic                            done_ff, done_in;
   logic [dcs_pkg::VAL_W-1:0]       res_ff, res_in;

   logic                            load_en;
   logic                            issue_en;
   logic                            round_en;
   logic                            last_term;
   logic [dcs_pkg::LIMB_W-1:0]      a_limb;
   logic [dcs_pkg::LIMB_W-1:0]      b_limb;
   logic [dcs_pkg::ACC_W-1:0]       pp_aligned;
   logic [dcs_pkg::ACC_W-1:0]       round_const;
   logic [dcs_pkg::ACC_W-1:0]       shifted;

   assign last_term = wide_ff ? (term_ff == 2'd3) : (term_ff == 2'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dcs_pkg::MUL_IDLE:  if (cmd.start) state_in = dcs_pkg::MUL_ISSUE;
         dcs_pkg::MUL_ISSUE: if (last_term) state_in = dcs_pkg::MUL_DRAIN;
         dcs_pkg::MUL_DRAIN: state_in = dcs_pkg::MUL_ROUND;
         dcs_pkg::MUL_ROUND: state_in = dcs_pkg::MUL_IDLE;
      endcase
   end

   // state decodes
   always_comb begin
      load_en  = 1'b0;
      issue_en = 1'b0;
      round_en = 1'b0;
      unique case (state_ff)
         dcs_pkg::MUL_IDLE:  load_en  = cmd.start;
         dcs_pkg::MUL_ISSUE: issue_en = 1'b1;
         dcs_pkg::MUL_DRAIN: ;
         dcs_pkg::MUL_ROUND: round_en = 1'b1;
      endcase
   end

   // limb order: a0*b0, a1*b0, a0*b1, a1*b1
   always_comb begin
      a_limb    = term_ff[0] ? mag_ff[63:32] : mag_ff[31:0];
      b_limb    = term_ff[1] ? y_ff[63:32] : y_ff[31:0];
      pp_in     = (2*dcs_pkg::LIMB_W)'(a_limb) * (2*dcs_pkg::LIMB_W)'(b_limb);
      pp_pos_in = 2'({1'b0, term_ff[0]} + {1'b0, term_ff[1]});
      pp_vld_in = issue_en;
      term_in   = issue_en ? term_ff + 2'd1 : term_ff;

      unique case (pp_pos_ff)
         2'd0:    pp_aligned = {64'd0, pp_ff};
         2'd1:    pp_aligned = {32'd0, pp_ff, 32'd0};
         2'd2:    pp_aligned = {pp_ff, 64'd0};
         default: pp_aligned = '0;
      endcase

      unique case (cmd.shift)
         dcs_pkg::SHIFT_NONE:   round_const = '0;
         dcs_pkg::SHIFT_CAP:    round_const = dcs_pkg::ACC_W'(1) << (dcs_pkg::CAP_FRAC - 1);
         dcs_pkg::SHIFT_CHARGE: round_const = dcs_pkg::ACC_W'(1) << (dcs_pkg::CHARGE_FRAC - 1);
         default:               round_const = '0;
      endcase

      unique case (shift_ff)
         dcs_pkg::SHIFT_NONE:   shifted = acc_ff;
         dcs_pkg::SHIFT_CAP:    shifted = acc_ff >> dcs_pkg::CAP_FRAC;
         dcs_pkg::SHIFT_CHARGE: shifted = acc_ff >> dcs_pkg::CHARGE_FRAC;
         default:               shifted = acc_ff;
      endcase

      neg_in   = neg_ff;
      mag_in   = mag_ff;
      y_in     = y_ff;
      wide_in  = wide_ff;
      shift_in = shift_ff;
      acc_in   = acc_ff;
      if (load_en) begin
         neg_in   = cmd.x[dcs_pkg::VAL_W-1];
         mag_in   = cmd.x[dcs_pkg::VAL_W-1] ? (dcs_pkg::VAL_W'(0) - cmd.x) : cmd.x;
         y_in     = cmd.y;
         wide_in  = (cmd.y[63:32] != '0);
         shift_in = cmd.shift;
         acc_in   = round_const;
         term_in  = 2'd0;
      end else if (pp_vld_ff) begin
         acc_in = acc_ff + pp_aligned;
      end

      // magnitude beyond 63 bits clamps on either sign
      if (shifted[dcs_pkg::ACC_W-1:dcs_pkg::VAL_W-1] != '0) begin
         res_in = neg_ff ? dcs_pkg::VAL_MIN : dcs_pkg::VAL_MAX;
      end else begin
         res_in = neg_ff ? (dcs_pkg::VAL_W'(0) - shifted[dcs_pkg::VAL_W-1:0])
                         : shifted[dcs_pkg::VAL_W-1:0];
      end
      done_in = round_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dcs_pkg::MUL_IDLE;
         pp_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pp_vld_ff <= pp_vld_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      y_ff      <= y_in;
      wide_ff   <= wide_in;
      shift_ff  <= shift_in;
      term_ff   <= term_in;
      pp_ff     <= pp_in;
      pp_pos_ff <= pp_pos_in;
      acc_ff    <= acc_in;
      if (round_en) res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

// File: hdl/dcs_seq.sv
`timescale 1ns / 1ps

// Walks the codes in order, drives the shared multiplier through the
// Horner chain and the capacitance and charge scaling, and keeps the nearest code.
module dcs_seq #(
   parameter int CODE_COUNT = dcs_pkg::CODE_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dcs_pkg::seq_cmd_type         cmd,
   input  logic                         ack,
   input  logic [dcs_pkg::COEF_W-1:0]   coef_cubic,
   input  logic [dcs_pkg::COEF_W-1:0]   coef_square,
   input  logic [dcs_pkg::COEF_W-1:0]   coef_linear,
   input  logic [dcs_pkg::COEF_W-1:0]   coef_offset,
   input  dcs_pkg::mul_rsp_type         mul_rsp,
   output dcs_pkg::mul_cmd_type         mul_cmd,
   output dcs_pkg::seq_sts_type         sts
);

   localparam int CW = $clog2(CODE_COUNT);
   localparam logic [CW-1:0] LAST_CODE = CW'(CODE_COUNT - 1);

   dcs_pkg::seq_state_type state_ff, state_in;
   dcs_pkg::step_type      step_ff, step_in;

   logic [CW-1:0]                  v_ff, v_in;
   logic [CW-1:0]                  best_ff, best_in;
   logic [dcs_pkg::DIST_W-1:0]     best_dist_ff, best_dist_in;
   logic [dcs_pkg::VAL_W-1:0]      p_ff, p_in;
   logic [dcs_pkg::TARGET_W-1:0]   target_ff, target_in;
   logic [dcs_pkg::CAP_W-1:0]      cap_ff, cap_in;

   logic [dcs_pkg::DIST_W-1:0]     target_ext;
   logic [dcs_pkg::DIST_W-1:0]     diff;
   logic [dcs_pkg::DIST_W-1:0]     code_dist;
   logic [dcs_pkg::DIST_W-1:0]     cmd_target_ext;

   function automatic logic [dcs_pkg::VAL_W-1:0] sext_coef(
      input logic [dcs_pkg::COEF_W-1:0] c);
      return {{(dcs_pkg::VAL_W-dcs_pkg::COEF_W){c[dcs_pkg::COEF_W-1]}}, c};
   endfunction

   function automatic logic [dcs_pkg::VAL_W-1:0] sat_add(
      input logic [dcs_pkg::VAL_W-1:0] a,
      input logic [dcs_pkg::VAL_W-1:0] b);
      logic [dcs_pkg::VAL_W:0] s;
      s = {a[dcs_pkg::VAL_W-1], a} + {b[dcs_pkg::VAL_W-1], b};
      if (s[dcs_pkg::VAL_W] != s[dcs_pkg::VAL_W-1])
         return s[dcs_pkg::VAL_W] ? dcs_pkg::VAL_MIN : dcs_pkg::VAL_MAX;
      return s[dcs_pkg::VAL_W-1:0];
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dcs_pkg::SEQ_IDLE:  if (cmd.start) state_in = dcs_pkg::SEQ_ISSUE;
         dcs_pkg::SEQ_ISSUE: state_in = dcs_pkg::SEQ_WAIT;
         dcs_pkg::SEQ_WAIT: begin
            if (mul_rsp.done) begin
               state_in = (step_ff == dcs_pkg::STEP_CHARGE) ? dcs_pkg::SEQ_DIST
                                                            : dcs_pkg::SEQ_ISSUE;
            end
         end
         dcs_pkg::SEQ_DIST:
            state_in = (v_ff == LAST_CODE) ? dcs_pkg::SEQ_DONE : dcs_pkg::SEQ_ISSUE;
         dcs_pkg::SEQ_DONE:  if (ack) state_in = dcs_pkg::SEQ_IDLE;
         default:            state_in = dcs_pkg::SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      mul_cmd.start = (state_ff == dcs_pkg::SEQ_ISSUE);
      mul_cmd.x     = p_ff;
      unique case (step_ff)
         dcs_pkg::STEP_CAP: begin
            mul_cmd.y     = dcs_pkg::VAL_W'(cap_ff);
            mul_cmd.shift = dcs_pkg::SHIFT_CAP;
         end
         dcs_pkg::STEP_CHARGE: begin
            mul_cmd.y     = dcs_pkg::CHARGE_SCALE;
            mul_cmd.shift = dcs_pkg::SHIFT_CHARGE;
         end
         default: begin
            mul_cmd.y     = dcs_pkg::VAL_W'(v_ff);
            mul_cmd.shift = dcs_pkg::SHIFT_NONE;
         end
      endcase
      sts.busy      = (state_ff != dcs_pkg::SEQ_IDLE);
      sts.done      = (state_ff == dcs_pkg::SEQ_DONE);
      sts.best_code = dcs_pkg::BEST_W'(best_ff);
   end

   // datapath
   always_comb begin
      // charge fits well inside DIST_W bits, so its low bits carry the sign
      target_ext = {{(dcs_pkg::DIST_W-dcs_pkg::TARGET_W){target_ff[dcs_pkg::TARGET_W-1]}},
                    target_ff};
      diff       = p_ff[dcs_pkg::DIST_W-1:0] - target_ext;
      code_dist  = diff[dcs_pkg::DIST_W-1] ? (dcs_pkg::DIST_W'(0) - diff) : diff;
      cmd_target_ext = {{(dcs_pkg::DIST_W-dcs_pkg::TARGET_W){cmd.target[dcs_pkg::TARGET_W-1]}},
                        cmd.target};

      step_in      = step_ff;
      v_in         = v_ff;
      best_in      = best_ff;
      best_dist_in = best_dist_ff;
      p_in         = p_ff;
      target_in    = target_ff;
      cap_in       = cap_ff;

      unique case (state_ff)
         dcs_pkg::SEQ_IDLE: begin
            if (cmd.start) begin
               p_in         = sext_coef(coef_cubic);
               v_in         = '0;
               step_in      = dcs_pkg::STEP_SQUARE;
               best_in      = '0;
               best_dist_in = cmd_target_ext[dcs_pkg::DIST_W-1]
                              ? (dcs_pkg::DIST_W'(0) - cmd_target_ext) : cmd_target_ext;
               target_in    = cmd.target;
               cap_in       = cmd.cap;
            end
         end
         dcs_pkg::SEQ_WAIT: begin
            if (mul_rsp.done) begin
               unique case (step_ff)
                  dcs_pkg::STEP_SQUARE: begin
                     p_in    = sat_add(mul_rsp.result, sext_coef(coef_square));
                     step_in = dcs_pkg::STEP_LINEAR;
                  end
                  dcs_pkg::STEP_LINEAR: begin
                     p_in    = sat_add(mul_rsp.result, sext_coef(coef_linear));
                     step_in = dcs_pkg::STEP_OFFSET;
                  end
                  dcs_pkg::STEP_OFFSET: begin
                     p_in    = sat_add(mul_rsp.result, sext_coef(coef_offset));
                     step_in = dcs_pkg::STEP_CAP;
                  end
                  dcs_pkg::STEP_CAP: begin
                     p_in    = mul_rsp.result;
                     step_in = dcs_pkg::STEP_CHARGE;
                  end
                  dcs_pkg::STEP_CHARGE: p_in = mul_rsp.result;
                  default:              step_in = dcs_pkg::STEP_SQUARE;
               endcase
            end
         end
         dcs_pkg::SEQ_DIST: begin
            // strictly nearer only, so ties keep the earlier code
            if (code_dist < best_dist_ff) begin
               best_dist_in = code_dist;
               best_in      = v_ff;
            end
            v_in    = v_ff + CW'(1);
            p_in    = sext_coef(coef_cubic);
            step_in = dcs_pkg::STEP_SQUARE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcs_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      v_ff         <= v_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      p_ff         <= p_in;
      target_ff    <= target_in;
      cap_ff       <= cap_in;
   end

endmodule

// File: hdl/dac_code_search_for_charge.sv
`timescale 1ns / 1ps

// Search: walks the codes in turn; the shared 32x32 multiplier serves five
//   products per code (2 + 2 + 2 + 2 + 4 limbs).
// Flow: one request at a time; req_tready is low while a search runs and
//   until its code is handed to the response register. A finished response
//   may wait in its register.
// Reset: synchronous, active high; clears control state and config registers.
module dac_code_search_for_charge #(
   parameter int CODE_COUNT = dcs_pkg::CODE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] target_charge (signed electrons)
   input  logic [1:0]  req_tuser,   // [1:0] cap_select

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] best_code, [15:10] zero

   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   logic [dcs_pkg::COEF_W-1:0] coef_cubic_ff,  coef_cubic_in;
   logic [dcs_pkg::COEF_W-1:0] coef_square_ff, coef_square_in;
   logic [dcs_pkg::COEF_W-1:0] coef_linear_ff, coef_linear_in;
   logic [dcs_pkg::COEF_W-1:0] coef_offset_ff, coef_offset_in;
   logic [dcs_pkg::CAP_W-1:0]  cap_high_ff,    cap_high_in;
   logic [dcs_pkg::CAP_W-1:0]  cap_medium_ff,  cap_medium_in;
   logic [dcs_pkg::CAP_W-1:0]  cap_low_ff,     cap_low_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dcs_pkg::BEST_W-1:0]  rsp_code_ff,  rsp_code_in;

   dcs_pkg::seq_cmd_type seq_cmd;
   dcs_pkg::seq_sts_type seq_sts;
   dcs_pkg::mul_cmd_type mul_cmd;
   dcs_pkg::mul_rsp_type mul_rsp;
   logic                 seq_ack;

   // Configuration writes; an index past the last register is dropped.
   always_comb begin
      coef_cubic_in  = coef_cubic_ff;
      coef_square_in = coef_square_ff;
      coef_linear_in = coef_linear_ff;
      coef_offset_in = coef_offset_ff;
      cap_high_in    = cap_high_ff;
      cap_medium_in  = cap_medium_ff;
      cap_low_in     = cap_low_ff;
      if (csr_wen) begin
         unique case (csr_index)
            dcs_pkg::REG_COEF_CUBIC:  coef_cubic_in  = csr_wdata;
            dcs_pkg::REG_COEF_SQUARE: coef_square_in = csr_wdata;
            dcs_pkg::REG_COEF_LINEAR: coef_linear_in = csr_wdata;
            dcs_pkg::REG_COEF_OFFSET: coef_offset_in = csr_wdata;
            dcs_pkg::REG_CAP_HIGH:    cap_high_in    = csr_wdata[dcs_pkg::CAP_W-1:0];
            dcs_pkg::REG_CAP_MEDIUM:  cap_medium_in  = csr_wdata[dcs_pkg::CAP_W-1:0];
            dcs_pkg::REG_CAP_LOW:     cap_low_in     = csr_wdata[dcs_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // Start a search on each accepted word; both high select codes pick the
   // high capacitance.
   assign req_tready = !seq_sts.busy;

   always_comb begin
      seq_cmd.start  = req_tvalid && req_tready;
      seq_cmd.target = req_tdata[dcs_pkg::TARGET_W-1:0];
      unique case (req_tuser)
         dcs_pkg::SEL_LOW:    seq_cmd.cap = cap_low_ff;
         dcs_pkg::SEL_MEDIUM: seq_cmd.cap = cap_medium_ff;
         default:             seq_cmd.cap = cap_high_ff;
      endcase
   end

   // Response register: load the finished code once the slot is free or
   // drains in the same cycle; hold it while the consumer stalls.
   assign seq_ack = seq_sts.done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      if (seq_ack) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = seq_sts.best_code;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(16 - dcs_pkg::BEST_W)'(0), rsp_code_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_cubic_ff  <= '0;
         coef_square_ff <= '0;
         coef_linear_ff <= '0;
         coef_offset_ff <= '0;
         cap_high_ff    <= '0;
         cap_medium_ff  <= '0;
         cap_low_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         coef_cubic_ff  <= coef_cubic_in;
         coef_square_ff <= coef_square_in;
         coef_linear_ff <= coef_linear_in;
         coef_offset_ff <= coef_offset_in;
         cap_high_ff    <= cap_high_in;
         cap_medium_ff  <= cap_medium_in;
         cap_low_ff     <= cap_low_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff <= rsp_code_in;
   end

   dcs_seq #(
      .CODE_COUNT (CODE_COUNT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cmd         (seq_cmd),
      .ack         (seq_ack),
      .coef_cubic  (coef_cubic_ff),
      .coef_square (coef_square_ff),
      .coef_linear (coef_linear_ff),
      .coef_offset (coef_offset_ff),
      .mul_rsp     (mul_rsp),
      .mul_cmd     (mul_cmd),
      .sts         (seq_sts)
   );

   dcs_mul_unit u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   // An accepted word always starts a search.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> seq_sts.busy)
      else $error("accepted request did not start a search");

   // A finished search is only reported while the sequencer is active.
   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      seq_sts.done |-> seq_sts.busy)
      else $error("search done outside an active search");

   // The response register only fills from a handed-over search result.
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(seq_ack))
      else $error("response word appeared without a finished search");

endmodule
